// File: src/u8pv_pkg.sv
`default_nettype none

package u8pv_pkg;

    // sequence length class, selects the overlong bound
    typedef logic [1:0] len_class_t;
    localparam len_class_t CLS_ONE   = 2'd0;
    localparam len_class_t CLS_TWO   = 2'd1;
    localparam len_class_t CLS_THREE = 2'd2;
    localparam len_class_t CLS_FOUR  = 2'd3;

    typedef logic [1:0]  pend_t;
    typedef logic [20:0] code_point_t;

    localparam pend_t PEND_NONE  = 2'd0;
    localparam pend_t PEND_ONE   = 2'd1;
    localparam pend_t PEND_TWO   = 2'd2;
    localparam pend_t PEND_THREE = 2'd3;

    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [7:0] LEAD2_BITS  = 8'h1F;
    localparam logic [7:0] LEAD3_BITS  = 8'h0F;
    localparam logic [7:0] LEAD4_BITS  = 8'h07;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_CODE   = 8'h80;
    localparam logic [7:0] CONT_BITS   = 8'h3F;

    localparam code_point_t MIN_TWO    = 21'h00080;
    localparam code_point_t MIN_THREE  = 21'h00800;
    localparam code_point_t MIN_FOUR   = 21'h10000;
    localparam code_point_t SURR_LO    = 21'h0D800;
    localparam code_point_t SURR_HI    = 21'h0DFFF;
    localparam code_point_t CP_MAX     = 21'h10FFFF;
    localparam code_point_t CP_TAB     = 21'h00009;
    localparam code_point_t CP_LF      = 21'h0000A;
    localparam code_point_t CP_CR      = 21'h0000D;
    localparam code_point_t CP_SPACE   = 21'h00020;
    localparam code_point_t CP_DEL     = 21'h0007F;

    function automatic logic allowed_text(input code_point_t cp);
        return (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR) ||
               ((cp >= CP_SPACE) && (cp != CP_DEL));
    endfunction

    function automatic logic finished_ok(input code_point_t cp, input len_class_t cls);
        code_point_t minimum;
        case (cls)
            CLS_TWO:   minimum = MIN_TWO;
            CLS_THREE: minimum = MIN_THREE;
            CLS_FOUR:  minimum = MIN_FOUR;
            default:   minimum = '0;
        endcase
        return (cp >= minimum) && !((cp >= SURR_LO) && (cp <= SURR_HI)) &&
               (cp <= CP_MAX) && allowed_text(cp);
    endfunction

endpackage

`default_nettype wire

// File: src/utf8_printable_text_validator_unit.sv
`default_nettype none

// Streams a string in one byte per request (s_tlast on the final byte) and
// returns one verdict request per string: m_tdata[0] is 1 when the whole
// string is well-formed printable UTF-8 (tab, LF, CR or any code point from
// U+0020 up, except U+007F, surrogates, overlong forms and values above
// U+10FFFF). A cut-off multi-byte sequence at the end fails. A byte request
// is taken every cycle unless a final byte waits for room in the result
// register; each byte sits in the input register, then the decode updates
// the sequence state, and a final byte writes its verdict into the result
// register, which drives m_tvalid. Throughput is one byte per cycle while
// the result register has room; a held verdict on the output stalls the
// next final byte and whatever follows it, not the ordinary bytes ahead of it.
module utf8_printable_text_validator_unit
    import u8pv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic       s_tlast,   // final_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] printable, [7:1] zero
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // sequence state
    pend_t       pending_reg, pending_next;
    code_point_t partial_reg, partial_next;
    len_class_t  class_reg, class_next;
    logic        failed_reg, failed_next;

    // result register
    logic out_valid_reg, out_valid_next;
    logic printable_reg, printable_next;

    logic out_free;
    logic advance;

    // working values of the decode
    pend_t       pend_dec;
    code_point_t cp_shift;
    logic        fail_now;
    pend_t       pend_upd;
    code_point_t part_upd;
    len_class_t  class_upd;
    logic        failed_upd;

    assign out_free = !out_valid_reg || m_tready;
    // a final byte waits for room in the result register
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // byte decode and state update
    always_comb
    begin
        pend_dec  = pending_reg - PEND_ONE;
        cp_shift  = {partial_reg[14:0], byte_reg[5:0] & CONT_BITS[5:0]};
        fail_now  = 1'b0;
        pend_upd  = pending_reg;
        part_upd  = partial_reg;
        class_upd = class_reg;

        if (!failed_reg)
        begin
            if (pending_reg == PEND_NONE)
            begin
                if (!byte_reg[7])
                begin
                    fail_now = !allowed_text({13'b0, byte_reg});
                end
                else if ((byte_reg & LEAD2_MASK) == LEAD2_CODE)
                begin
                    part_upd  = {13'b0, byte_reg & LEAD2_BITS};
                    pend_upd  = PEND_ONE;
                    class_upd = CLS_TWO;
                end
                else if ((byte_reg & LEAD3_MASK) == LEAD3_CODE)
                begin
                    part_upd  = {13'b0, byte_reg & LEAD3_BITS};
                    pend_upd  = PEND_TWO;
                    class_upd = CLS_THREE;
                end
                else if ((byte_reg & LEAD4_MASK) == LEAD4_CODE)
                begin
                    part_upd  = {13'b0, byte_reg & LEAD4_BITS};
                    pend_upd  = PEND_THREE;
                    class_upd = CLS_FOUR;
                end
                else
                begin
                    fail_now = 1'b1;
                end
            end
            else if ((byte_reg & CONT_MASK) != CONT_CODE)
            begin
                fail_now = 1'b1;
            end
            else
            begin
                part_upd = cp_shift;
                pend_upd = pend_dec;
                fail_now = (pend_dec == PEND_NONE) && !finished_ok(cp_shift, class_reg);
            end
        end

        failed_upd = failed_reg || fail_now;
        if (fail_now)
        begin
            pend_upd = PEND_NONE;
        end
    end

    always_comb
    begin
        pending_next   = pending_reg;
        partial_next   = partial_reg;
        class_next     = class_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg && !m_tready;
        printable_next = printable_reg;
        if (advance)
        begin
            if (last_reg)
            begin
                // verdict out, state back to its start
                out_valid_next = 1'b1;
                printable_next = !failed_upd && (pend_upd == PEND_NONE);
                pending_next   = PEND_NONE;
                partial_next   = '0;
                class_next     = CLS_ONE;
                failed_next    = 1'b0;
            end
            else
            begin
                pending_next = pend_upd;
                partial_next = part_upd;
                class_next   = class_upd;
                failed_next  = failed_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pending_reg   <= PEND_NONE;
            partial_reg   <= '0;
            class_reg     <= CLS_ONE;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            pending_reg   <= pending_next;
            partial_reg   <= partial_next;
            class_reg     <= class_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        printable_reg <= printable_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, printable_reg};

    // a failure never leaves continuations pending
    a_fail_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> (pending_reg == PEND_NONE))
        else $error("pending continuations while failed");

    // a final byte always produces a verdict
    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> out_valid_reg)
        else $error("final byte without verdict");

    // state is back at reset after a final byte
    a_final_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> (!failed_reg && (pending_reg == PEND_NONE)
                                   && (partial_reg == '0)))
        else $error("state not cleared after final byte");

endmodule

`default_nettype wire

// File: dv/tb_utf8_printable_text_validator_unit.sv
`default_nettype none

module tb_utf8_printable_text_validator_unit;
    import u8pv_pkg::*;

    // cycles with no request on either side before the run is abandoned
    localparam int QUIET_LIMIT  = 2000;
    // long receiver hold-off so the held verdict backs up the byte side
    localparam int HOLD_CYCLES  = 300;
    // margin after the last predicted verdict has been checked
    localparam int DRAIN_CYCLES = 10;

    // one byte request as offered to the slave side
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } text_req_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] text_byte
    logic       s_tlast  = 1'b0;    // final_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] printable, [7:1] zero

    text_req_t  text_q[$];      // byte requests waiting for the driver
    logic       verdict_q[$];   // predicted verdicts, oldest first
    logic [7:0] str_bytes[$];   // string under construction

    int  idle_pct        = 23;
    bit  hold_trigger    = 1'b0;
    bit  byte_taken      = 1'b0;
    int  bytes_sent      = 0;
    int  bytes_accepted  = 0;
    int  mismatch_count  = 0;
    int  hold_left       = 0;
    int  quiet_cycles    = 0;
    text_req_t next_req;

    // decoder state of the predictor
    pend_t       dec_left   = PEND_NONE;
    code_point_t dec_value  = '0;
    len_class_t  dec_class  = CLS_ONE;
    bit          dec_failed = 1'b0;

    utf8_printable_text_validator_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // tab, lf, cr, or anything from space up except del
    function automatic bit is_text_char(code_point_t cp);
        return (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR) ||
               ((cp >= CP_SPACE) && (cp != CP_DEL));
    endfunction

    // finished multi-byte sequence: not overlong, no surrogate, in range, allowed text
    function automatic bit sequence_legal(code_point_t cp, len_class_t cls);
        code_point_t lowest;
        case (cls)
            CLS_TWO:   lowest = MIN_TWO;
            CLS_THREE: lowest = MIN_THREE;
            CLS_FOUR:  lowest = MIN_FOUR;
            default:   lowest = '0;
        endcase
        if (cp < lowest)
            return 1'b0;
        if ((cp >= SURR_LO) && (cp <= SURR_HI))
            return 1'b0;
        if (cp > CP_MAX)
            return 1'b0;
        return is_text_char(cp);
    endfunction

    // sticky failure also drops any pending continuations
    task automatic mark_failed();
        dec_failed = 1'b1;
        dec_left   = PEND_NONE;
    endtask

    task automatic predict_text_byte(logic [7:0] b, logic last);
        logic verdict;
        if (!dec_failed)
        begin
            if (dec_left == PEND_NONE)
            begin
                if (b[7] == 1'b0)
                begin
                    if (!is_text_char(code_point_t'(b)))
                        mark_failed();
                end
                else if ((b & LEAD2_MASK) == LEAD2_CODE)
                begin
                    dec_value = code_point_t'(b & LEAD2_BITS);
                    dec_left  = PEND_ONE;
                    dec_class = CLS_TWO;
                end
                else if ((b & LEAD3_MASK) == LEAD3_CODE)
                begin
                    dec_value = code_point_t'(b & LEAD3_BITS);
                    dec_left  = PEND_TWO;
                    dec_class = CLS_THREE;
                end
                else if ((b & LEAD4_MASK) == LEAD4_CODE)
                begin
                    dec_value = code_point_t'(b & LEAD4_BITS);
                    dec_left  = PEND_THREE;
                    dec_class = CLS_FOUR;
                end
                else
                begin
                    // stray continuation or 0xf8..0xff as a lead
                    mark_failed();
                end
            end
            else if ((b & CONT_MASK) != CONT_CODE)
            begin
                // broken continuation, the byte is not reused as a lead
                mark_failed();
            end
            else
            begin
                dec_value = {dec_value[14:0], b[5:0]};
                dec_left  = dec_left - 2'd1;
                if ((dec_left == PEND_NONE) && !sequence_legal(dec_value, dec_class))
                    mark_failed();
            end
        end
        if (last)
        begin
            // cut-off sequence at the end also fails
            verdict    = !dec_failed && (dec_left == PEND_NONE);
            verdict_q  = {verdict_q, verdict};
            dec_left   = PEND_NONE;
            dec_value  = '0;
            dec_class  = CLS_ONE;
            dec_failed = 1'b0;
        end
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic put_byte(logic [7:0] b, logic last);
        text_req_t req;
        req.text_byte  = b;
        req.final_byte = last;
        text_q = {text_q, req};
        bytes_sent++;
    endtask

    // append one byte to the string under construction
    task automatic add_byte(logic [7:0] b);
        str_bytes = {str_bytes, b};
    endtask

    // standard utf-8 layout of cp in n_bytes bytes, overlong if n_bytes is too big
    task automatic encode_cp(code_point_t cp, int n_bytes);
        case (n_bytes)
            1: add_byte({1'b0, cp[6:0]});
            2:
            begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // one character, usually well formed, sometimes with a planted defect
    task automatic add_char();
        int          kind;
        int          n;
        int          start;
        int          idx;
        logic [7:0]  r;
        code_point_t cp;
        start = str_bytes.size();
        if ($urandom_range(99) < 10)
        begin
            kind = $urandom_range(0, 5);
            case (kind)
                0: add_byte(8'($urandom_range(0, 255)));
                1:
                begin
                    // overlong form
                    n = $urandom_range(2, 4);
                    cp = (n == 2) ? code_point_t'($urandom_range(0, 'h7F)) :
                         (n == 3) ? code_point_t'($urandom_range(0, 'h7FF)) :
                                    code_point_t'($urandom_range(0, 'hFFFF));
                    encode_cp(cp, n);
                end
                2: encode_cp(code_point_t'($urandom_range('hD800, 'hDFFF)), 3);
                3: encode_cp(code_point_t'($urandom_range('h110000, 'h1FFFFF)), 4);
                4:
                begin
                    // sequence cut short
                    n = $urandom_range(2, 4);
                    encode_cp(code_point_t'($urandom_range('h10000, 'h10FFFF)), n);
                    repeat ($urandom_range(1, n - 1))
                        void'(str_bytes.pop_back());
                end
                default:
                begin
                    // continuation byte replaced by a non-continuation
                    n = $urandom_range(2, 4);
                    encode_cp(code_point_t'($urandom_range('h10000, 'h10FFFF)), n);
                    idx = start + $urandom_range(1, n - 1);
                    r = 8'($urandom_range(0, 255));
                    if (r[7:6] == 2'b10)
                        r[6] = 1'b1;
                    str_bytes[idx] = r;
                end
            endcase
        end
        else
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                4:
                begin
                    // control characters, mostly the allowed ones
                    if ($urandom_range(1) == 0)
                        cp = code_point_t'($urandom_range(0, 31));
                    else
                        cp = ($urandom_range(2) == 0) ? CP_TAB :
                             ($urandom_range(1) == 0) ? CP_LF : CP_CR;
                    encode_cp(cp, 1);
                end
                5: encode_cp(code_point_t'($urandom_range('h80, 'h7FF)), 2);
                6: encode_cp(code_point_t'($urandom_range('h800, 'hFFFF)), 3);
                7: encode_cp(code_point_t'($urandom_range('h10000, 'h10FFFF)), 4);
                default: encode_cp(code_point_t'($urandom_range('h20, 'h7F)), 1);
            endcase
        end
    endtask

    task automatic push_string(int n_chars);
        int i;
        str_bytes.delete();
        if ($urandom_range(99) < 12)
        begin
            // raw noise
            for (i = 0; i < n_chars; i++)
                add_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            for (i = 0; i < n_chars; i++)
                add_char();
        end
        for (i = 0; i < str_bytes.size(); i++)
            put_byte(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    task automatic push_random_until(int total);
        while (bytes_sent < total)
            push_string(($urandom_range(99) < 85) ? $urandom_range(1, 6) :
                                                   $urandom_range(7, 24));
    endtask

    task automatic wait_all_taken();
        while (bytes_accepted != bytes_sent)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // driver: byte requests change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        // keep an offered request until the rising edge took it
        if (rst_n && !(s_tvalid && !byte_taken))
        begin
            if ((text_q.size() != 0) && ($urandom_range(99) >= idle_pct))
            begin
                next_req = text_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_req.text_byte;
                s_tlast  <= next_req.final_byte;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random idling plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_trigger)
        begin
            hold_left    = HOLD_CYCLES;
            hold_trigger = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: both sides sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        logic expected;
        byte_taken <= rst_n && s_tvalid && (s_tready === 1'b1);
        if (rst_n)
        begin
            // check the verdict first, its own string was taken cycles ago
            if ((m_tvalid === 1'b1) && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch($sformatf("verdict %b with no string pending", m_tdata));
                end
                else
                begin
                    expected = verdict_q.pop_front();
                    if (m_tdata[0] !== expected)
                        report_mismatch($sformatf("printable %b, predicted %b",
                                                  m_tdata[0], expected));
                    if (m_tdata[7:1] !== 7'd0)
                        report_mismatch($sformatf("padding bits %b not zero", m_tdata[7:1]));
                end
            end
            if (s_tvalid && (s_tready === 1'b1))
            begin
                predict_text_byte(s_tdata, s_tlast);
                bytes_accepted++;
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && (s_tready === 1'b1)) || ((m_tvalid === 1'b1) && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed strings: extremes, allowed controls, each kind of defect
        put_byte(8'h00, 1'b1);                          // nul rejected
        put_byte(8'hFF, 1'b1);                          // invalid lead
        put_byte(8'h09, 1'b0); put_byte(8'h0A, 1'b0);   // tab, lf, cr, space, tilde
        put_byte(8'h0D, 1'b0); put_byte(8'h20, 1'b0);
        put_byte(8'h7E, 1'b1);
        put_byte(8'h7F, 1'b1);                          // del rejected
        put_byte(8'h80, 1'b1);                          // continuation as lead
        put_byte(8'hC0, 1'b0); put_byte(8'h80, 1'b1);   // overlong two-byte
        put_byte(8'hDF, 1'b0); put_byte(8'hBF, 1'b1);   // top of two-byte range
        put_byte(8'hE0, 1'b0); put_byte(8'h9F, 1'b0);   // overlong three-byte
        put_byte(8'hBF, 1'b1);
        put_byte(8'hED, 1'b0); put_byte(8'hA0, 1'b0);   // surrogate
        put_byte(8'h80, 1'b1);
        put_byte(8'hF4, 1'b0); put_byte(8'h90, 1'b0);   // above u+10ffff
        put_byte(8'h80, 1'b0); put_byte(8'h80, 1'b1);
        put_byte(8'hC2, 1'b0); put_byte(8'h41, 1'b1);   // broken continuation
        put_byte(8'hE2, 1'b0); put_byte(8'h82, 1'b1);   // cut off at the end

        // random strings with idling on both sides
        push_random_until(500);
        wait_all_taken();

        // long stretch with no idling at all
        idle_pct = 0;
        push_random_until(800);
        wait_all_taken();

        // receiver holds off while many short strings keep coming
        idle_pct = 23;
        hold_trigger = 1'b1;
        for (i = 0; i < 80; i++)
            push_string($urandom_range(1, 2));
        wait_all_taken();

        push_random_until(1200);
        wait_all_taken();

        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
